// ===== hdl/ph32_pkg.sv =====
package ph32_pkg;

  localparam logic [15:0] DEFAULT_BUCKETS = 16'd113;

  localparam logic [7:0] PERM_TABLE [256] = '{
    8'd98,  8'd6,   8'd85,  8'd150, 8'd36,  8'd23,  8'd112, 8'd164,
    8'd135, 8'd207, 8'd169, 8'd5,   8'd26,  8'd64,  8'd165, 8'd219,
    8'd61,  8'd20,  8'd68,  8'd89,  8'd130, 8'd63,  8'd52,  8'd102,
    8'd24,  8'd229, 8'd132, 8'd245, 8'd80,  8'd216, 8'd195, 8'd115,
    8'd90,  8'd168, 8'd156, 8'd203, 8'd177, 8'd120, 8'd2,   8'd190,
    8'd188, 8'd7,   8'd100, 8'd185, 8'd174, 8'd243, 8'd162, 8'd10,
    8'd237, 8'd18,  8'd253, 8'd225, 8'd8,   8'd208, 8'd172, 8'd244,
    8'd255, 8'd126, 8'd101, 8'd79,  8'd145, 8'd235, 8'd228, 8'd121,
    8'd123, 8'd251, 8'd67,  8'd250, 8'd161, 8'd0,   8'd107, 8'd97,
    8'd241, 8'd111, 8'd181, 8'd82,  8'd249, 8'd33,  8'd69,  8'd55,
    8'd59,  8'd153, 8'd29,  8'd9,   8'd213, 8'd167, 8'd84,  8'd93,
    8'd30,  8'd46,  8'd94,  8'd75,  8'd151, 8'd114, 8'd73,  8'd222,
    8'd197, 8'd96,  8'd210, 8'd45,  8'd16,  8'd227, 8'd248, 8'd202,
    8'd51,  8'd152, 8'd252, 8'd125, 8'd81,  8'd206, 8'd215, 8'd186,
    8'd39,  8'd158, 8'd178, 8'd187, 8'd131, 8'd136, 8'd1,   8'd49,
    8'd50,  8'd17,  8'd141, 8'd91,  8'd47,  8'd129, 8'd60,  8'd99,
    8'd154, 8'd35,  8'd86,  8'd171, 8'd105, 8'd34,  8'd38,  8'd200,
    8'd147, 8'd58,  8'd77,  8'd118, 8'd173, 8'd246, 8'd76,  8'd254,
    8'd133, 8'd232, 8'd196, 8'd144, 8'd198, 8'd124, 8'd53,  8'd4,
    8'd108, 8'd74,  8'd223, 8'd234, 8'd134, 8'd230, 8'd157, 8'd139,
    8'd189, 8'd205, 8'd199, 8'd128, 8'd176, 8'd19,  8'd211, 8'd236,
    8'd127, 8'd192, 8'd231, 8'd70,  8'd233, 8'd88,  8'd146, 8'd44,
    8'd183, 8'd201, 8'd22,  8'd83,  8'd13,  8'd214, 8'd116, 8'd109,
    8'd159, 8'd32,  8'd95,  8'd226, 8'd140, 8'd220, 8'd57,  8'd12,
    8'd221, 8'd31,  8'd209, 8'd182, 8'd143, 8'd92,  8'd149, 8'd184,
    8'd148, 8'd62,  8'd113, 8'd65,  8'd37,  8'd27,  8'd106, 8'd166,
    8'd3,   8'd14,  8'd204, 8'd72,  8'd21,  8'd41,  8'd56,  8'd66,
    8'd28,  8'd193, 8'd40,  8'd217, 8'd25,  8'd54,  8'd179, 8'd117,
    8'd238, 8'd87,  8'd240, 8'd155, 8'd180, 8'd170, 8'd242, 8'd212,
    8'd191, 8'd163, 8'd78,  8'd218, 8'd137, 8'd194, 8'd175, 8'd110,
    8'd43,  8'd119, 8'd224, 8'd71,  8'd122, 8'd142, 8'd42,  8'd160,
    8'd104, 8'd48,  8'd247, 8'd103, 8'd15,  8'd11,  8'd138, 8'd239
  };

  typedef struct packed {
    logic       start;
    logic [7:0] key_byte;
    logic       last_byte;
  } ph32_lane_req_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [15:0] divisor;
  } ph32_div_req_t;

  function automatic logic [7:0] ph32_perm(input logic [7:0] idx);
    return PERM_TABLE[idx];
  endfunction

endpackage

// ===== hdl/ph32_if.sv =====
interface ph32_key_if;
  logic       valid;
  logic       ready;
  logic [7:0] key_byte;
  logic       last_byte;

  modport source (output valid, output key_byte, output last_byte, input ready);
  modport sink (input valid, input key_byte, input last_byte, output ready);
endinterface

interface ph32_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] hash_value;
  logic [15:0] bucket_index;

  modport source (output valid, output hash_value, output bucket_index, input ready);
  modport sink (input valid, input hash_value, input bucket_index, output ready);
endinterface

interface ph32_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] bucket_count;

  modport source (output valid, output bucket_count, input ready);
  modport sink (input valid, input bucket_count, output ready);
endinterface

// ===== hdl/ph32_lane_unit.sv =====
module ph32_lane_unit
  import ph32_pkg::*;
#(
  parameter int LANES = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  ph32_lane_req_t req,
  output logic           done,
  output logic [31:0]    hash
);

  localparam int IDX_W = (LANES > 1) ? $clog2(LANES) : 1;

  logic [7:0]       lanes [LANES];
  logic [IDX_W-1:0] idx;
  logic             busy;
  logic             at_start;
  logic [7:0]       key_byte;
  logic             last_byte;
  logic [7:0]       seed;
  logic [7:0]       cur;
  logic [7:0]       lane_next;

  assign done = busy && (idx == IDX_W'(LANES - 1));

  always_comb begin
    seed      = ph32_perm(key_byte + 8'(idx));
    cur       = at_start ? seed : lanes[idx];
    lane_next = ph32_perm(cur ^ key_byte);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      at_start <= 1'b1;
      idx      <= '0;
      for (int j = 0; j < LANES; j++) begin
        lanes[j] <= 8'd0;
      end
    end else if (req.start) begin
      busy      <= 1'b1;
      idx       <= '0;
      key_byte  <= req.key_byte;
      last_byte <= req.last_byte;
    end else if (busy) begin
      lanes[idx] <= lane_next;
      if (done) begin
        busy     <= 1'b0;
        at_start <= last_byte;
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

  // lanes beyond the fourth stay internal
  // the lane being updated shows its new value so the hash is complete with done
  for (genvar j = 0; j < 4; j++) begin : g_pack
    if (j < LANES) begin : g_lane
      assign hash[8*j +: 8] = (busy && (idx == IDX_W'(j))) ? lane_next : lanes[j];
    end else begin : g_zero
      assign hash[8*j +: 8] = 8'd0;
    end
  end

endmodule

// ===== hdl/ph32_div_unit.sv =====
module ph32_div_unit
  import ph32_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  ph32_div_req_t req,
  output logic          rem_valid,
  output logic [15:0]   remainder
);

  localparam logic [4:0] CNT_LAST = 5'd31;

  logic [31:0] dvd;
  logic [15:0] dvs;
  logic [15:0] rem;
  logic [4:0]  cnt;
  logic        busy;
  logic [16:0] trial;
  logic        ge;
  logic [15:0] rem_next;

  always_comb begin
    trial    = {rem, dvd[31]};
    ge       = trial >= {1'b0, dvs};
    rem_next = ge ? 16'(trial - {1'b0, dvs}) : trial[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      rem_valid <= 1'b0;
      cnt       <= '0;
    end else if (req.start) begin
      dvd       <= req.dividend;
      dvs       <= req.divisor;
      rem       <= 16'd0;
      cnt       <= CNT_LAST;
      busy      <= 1'b1;
      rem_valid <= 1'b0;
    end else if (busy) begin
      rem <= rem_next;
      dvd <= {dvd[30:0], 1'b0};
      if (cnt == 5'd0) begin
        busy      <= 1'b0;
        rem_valid <= 1'b1;
      end else begin
        cnt <= cnt - 5'd1;
      end
    end
  end

  assign remainder = rem;

endmodule

// ===== hdl/pearson_hash32_bucket_index_core.sv =====
// each key byte steps through all LANES lanes in turn via permutation table lookups
// a final byte adds 32 restoring remainder steps plus one output load
// the result register lets the next key byte enter while a result waits
// synchronous reset: lanes cleared, next byte starts a key, bucket_count = 113
module pearson_hash32_bucket_index_core
  import ph32_pkg::*;
#(
  parameter int LANES = 4
) (
  input  logic               clk,
  input  logic               rst,
  ph32_key_if.sink           key,
  ph32_result_if.source      result,
  ph32_cfg_if.sink           cfg
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_LANE = 3'b010,
    S_DIV  = 3'b100
  } state_t;

  state_t         state;
  state_t         state_next;
  logic [15:0]    bucket_count;
  logic           last_q;
  logic           out_valid;
  logic [31:0]    out_hash;
  logic [15:0]    out_index;
  logic           accept;
  logic           lane_done;
  logic [31:0]    lane_hash;
  logic           rem_valid;
  logic [15:0]    remainder;
  logic           load;
  ph32_lane_req_t lane_req;
  ph32_div_req_t  div_req;

  assign key.ready = (state == S_IDLE);
  assign accept    = key.valid && key.ready;
  assign cfg.ready = 1'b1;

  assign lane_req = '{start: accept, key_byte: key.key_byte, last_byte: key.last_byte};

  assign div_req = '{
    start:    (state == S_LANE) && lane_done && last_q,
    dividend: lane_hash,
    divisor:  (bucket_count == 16'd0) ? DEFAULT_BUCKETS : bucket_count
  };

  assign load = (state == S_DIV) && rem_valid && (!out_valid || result.ready);

  ph32_lane_unit #(.LANES(LANES)) u_lane (
    .clk  (clk),
    .rst  (rst),
    .req  (lane_req),
    .done (lane_done),
    .hash (lane_hash)
  );

  ph32_div_unit u_div (
    .clk       (clk),
    .rst       (rst),
    .req       (div_req),
    .rem_valid (rem_valid),
    .remainder (remainder)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) state_next = S_LANE;
      end
      S_LANE: begin
        if (lane_done) state_next = last_q ? S_DIV : S_IDLE;
      end
      S_DIV: begin
        if (load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      bucket_count <= DEFAULT_BUCKETS;
      out_valid    <= 1'b0;
      last_q       <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid && cfg.ready) bucket_count <= cfg.bucket_count;
      if (accept) last_q <= key.last_byte;
      if (load) begin
        out_valid <= 1'b1;
        out_hash  <= lane_hash;
        out_index <= remainder;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign result.valid        = out_valid;
  assign result.hash_value   = out_hash;
  assign result.bucket_index = out_index;

endmodule
